>>> rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, constants and the structs passed between the frame store,
// the scan unit and the sequencer.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Table geometry
  localparam int FRAMES      = 128;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int CNT_W       = FRAME_W + 1;
  localparam int AGE_W       = FRAME_W;
  localparam int PAGE_W      = 8;
  localparam int FAULT_W     = 16;
  localparam int OUT_FRAME_W = 7;

  localparam logic [CNT_W-1:0]   FRAMES_CNT = CNT_W'(FRAMES);
  localparam logic [FAULT_W-1:0] FAULT_MAX  = '1;

  // One frame entry as read from the frame store
  typedef struct packed {
    logic              vld;
    logic [PAGE_W-1:0] page;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // Operands the sequencer holds for the scan unit
  typedef struct packed {
    logic [PAGE_W-1:0] key;
    logic [AGE_W-1:0]  limit;
    logic              all;
    logic [AGE_W-1:0]  best;
  } scan_ctl_t;

  // Per-entry verdicts from the scan unit
  typedef struct packed {
    logic             match;
    logic             empty;
    logic             older;
    logic             bump;
    logic [AGE_W-1:0] age_inc;
  } scan_res_t;

  // Write request into the frame store
  typedef struct packed {
    logic               we_page;
    logic               we_age;
    logic [FRAME_W-1:0] addr;
    logic [PAGE_W-1:0]  page;
    logic [AGE_W-1:0]   age;
  } mem_wr_t;

endpackage

>>> rtl/lru_frame_mem.sv
// ----------------------------------------------------------------------------
// LRU frame store
// Page tag and age rank memories, one write and one registered read per
// cycle. Occupancy flops mark written frames; an empty frame reads with vld low.
// ----------------------------------------------------------------------------
module lru_frame_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lru_pkg::FRAME_W-1:0] raddr,
  input  lru_pkg::mem_wr_t            wr,
  output lru_pkg::entry_t             rd
);

  logic [lru_pkg::PAGE_W-1:0] page_mem [lru_pkg::FRAMES];
  logic [lru_pkg::AGE_W-1:0]  age_mem  [lru_pkg::FRAMES];
  logic [lru_pkg::FRAMES-1:0] occ;

  // Memory writes
  always_ff @(posedge clk) begin
    if (wr.we_page) begin
      page_mem[wr.addr] <= wr.page;
    end
    if (wr.we_age) begin
      age_mem[wr.addr] <= wr.age;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd.page <= page_mem[raddr];
    rd.age  <= age_mem[raddr];
    rd.vld  <= occ[raddr];
  end

  // Occupancy: a frame once filled stays filled
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (wr.we_page) begin
      occ[wr.addr] <= 1'b1;
    end
  end

endmodule

>>> rtl/lru_scan_unit.sv
// ----------------------------------------------------------------------------
// LRU scan unit
// The one compare/increment unit, applied to one frame entry per cycle in
// both the search pass and the aging pass.
// ----------------------------------------------------------------------------
module lru_scan_unit (
  input  lru_pkg::entry_t    ent,
  input  lru_pkg::scan_ctl_t ctl,
  output lru_pkg::scan_res_t res
);

  // Tag compare, empty detect, rank max compare
  assign res.match = ent.vld && (ent.page == ctl.key);
  assign res.empty = !ent.vld;
  assign res.older = ent.vld && (ent.age > ctl.best);

  // Aging: resident frames more recent than the limit, or every resident frame when all is set, move one rank down
  assign res.bump    = ent.vld && (ctl.all || (ent.age < ctl.limit));
  assign res.age_inc = ent.age + lru_pkg::AGE_W'(1);

endmodule

>>> rtl/lru_page_replacement_unit.sv
// Sequence: a nonzero page runs the search pass, the plan state, the aging pass
//   and the commit state before its result; page zero gives it without a pass.
// A new page is taken only while idle; each nonzero page takes two passes of the
//   shared scan unit over the frame store (search, then aging), one frame a cycle.
// Reset clears occupancy, resident count and fault count.
// Results are shown for one cycle under done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative LRU replacement over FRAMES frames with a per-frame
// recency rank and a saturating fault counter.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lru_pkg::PAGE_W-1:0]      page,
  output logic                            done,
  output logic                            hit,
  output logic [lru_pkg::OUT_FRAME_W-1:0] frame,
  output logic [lru_pkg::PAGE_W-1:0]      evicted_page,
  output logic [lru_pkg::FAULT_W-1:0]     fault_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PLAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]                  state;
  logic [lru_pkg::CNT_W-1:0]   cnt;
  logic [lru_pkg::FRAME_W-1:0] idx_q;
  logic [lru_pkg::PAGE_W-1:0]  key;
  logic                        found;
  logic [lru_pkg::FRAME_W-1:0] hit_idx;
  logic [lru_pkg::AGE_W-1:0]   hit_age;
  logic [lru_pkg::FRAME_W-1:0] empty_idx;
  logic [lru_pkg::AGE_W-1:0]   best;
  logic [lru_pkg::FRAME_W-1:0] best_idx;
  logic [lru_pkg::PAGE_W-1:0]  best_page;
  logic [lru_pkg::FRAME_W-1:0] tgt;
  logic [lru_pkg::AGE_W-1:0]   limit;
  logic                        all_flag;
  logic [lru_pkg::PAGE_W-1:0]  evict_pg;
  logic [lru_pkg::CNT_W-1:0]   resident;
  logic [lru_pkg::FAULT_W-1:0] faults;

  logic                                          eval;
  logic [lru_pkg::FRAME_W+lru_pkg::OUT_FRAME_W-1:0] tgt_ext;
  lru_pkg::entry_t                               rd;
  lru_pkg::mem_wr_t                              wr;
  lru_pkg::scan_ctl_t                            ctl;
  lru_pkg::scan_res_t                            res;

  assign busy        = (state != S_IDLE);
  assign fault_count = faults;
  assign eval        = (cnt != '0);
  assign tgt_ext     = {{lru_pkg::OUT_FRAME_W{1'b0}}, tgt};

  // Frame store
  lru_frame_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .raddr (cnt[lru_pkg::FRAME_W-1:0]),
    .wr    (wr),
    .rd    (rd)
  );

  // Shared compare/increment unit
  assign ctl.key   = key;
  assign ctl.limit = limit;
  assign ctl.all   = all_flag;
  assign ctl.best  = best;

  lru_scan_unit u_scan (
    .ent (rd),
    .ctl (ctl),
    .res (res)
  );

  // Store writes: aged ranks during the update pass, target frame at commit
  always_comb begin
    wr.we_page = (state == S_COMMIT);
    wr.we_age  = (state == S_COMMIT) || ((state == S_UPDATE) && eval && res.bump);
    wr.addr    = (state == S_COMMIT) ? tgt : idx_q;
    wr.page    = key;
    wr.age     = (state == S_COMMIT) ? '0 : res.age_inc;
  end

  // Entry index that lines up with the registered read data
  always_ff @(posedge clk) begin
    idx_q <= cnt[lru_pkg::FRAME_W-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      resident <= '0;
      faults   <= '0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key <= page;
            if (page == '0) begin
              // Page zero: no state change, immediate result
              done         <= 1'b1;
              hit          <= 1'b0;
              frame        <= '0;
              evicted_page <= '0;
            end else begin
              state     <= S_SCAN;
              cnt       <= '0;
              found     <= 1'b0;
              best      <= '0;
              best_idx  <= '0;
              empty_idx <= '0;
            end
          end
        end
        S_SCAN: begin
          if (eval) begin
            if (res.match && !found) begin
              found   <= 1'b1;
              hit_idx <= idx_q;
              hit_age <= rd.age;
            end
            if (res.empty) begin
              empty_idx <= idx_q;
            end
            // Oldest frame, lowest index wins a tie
            if (res.older) begin
              best      <= rd.age;
              best_idx  <= idx_q;
              best_page <= rd.page;
            end else if (idx_q == '0) begin
              best_page <= rd.page;
            end
          end
          if (cnt == lru_pkg::FRAMES_CNT) begin
            state <= S_PLAN;
          end else begin
            cnt <= cnt + lru_pkg::CNT_W'(1);
          end
        end
        S_PLAN: begin
          cnt <= '0;
          state <= S_UPDATE;
          if (found) begin
            tgt      <= hit_idx;
            limit    <= hit_age;
            all_flag <= 1'b0;
            evict_pg <= '0;
          end else if (resident != lru_pkg::FRAMES_CNT) begin
            tgt      <= empty_idx;
            limit    <= '0;
            all_flag <= 1'b1;
            evict_pg <= '0;
          end else begin
            tgt      <= best_idx;
            limit    <= best;
            all_flag <= 1'b0;
            evict_pg <= best_page;
          end
        end
        S_UPDATE: begin
          if (cnt == lru_pkg::FRAMES_CNT) begin
            state <= S_COMMIT;
          end else begin
            cnt <= cnt + lru_pkg::CNT_W'(1);
          end
        end
        S_COMMIT: begin
          state        <= S_IDLE;
          cnt          <= '0;
          done         <= 1'b1;
          hit          <= found;
          frame        <= tgt_ext[lru_pkg::OUT_FRAME_W-1:0];
          evicted_page <= evict_pg;
          if (!found) begin
            if (faults != lru_pkg::FAULT_MAX) begin
              faults <= faults + lru_pkg::FAULT_W'(1);
            end
            if (resident != lru_pkg::FRAMES_CNT) begin
              resident <= resident + lru_pkg::CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lru_checker.sv
// ----------------------------------------------------------------------------
// LRU port checker
// Watches the top level's ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
module lru_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [lru_pkg::PAGE_W-1:0]      page,
  input logic                            done,
  input logic                            hit,
  input logic [lru_pkg::OUT_FRAME_W-1:0] frame,
  input logic [lru_pkg::PAGE_W-1:0]      evicted_page,
  input logic [lru_pkg::FAULT_W-1:0]     fault_count
);

  // A result is only shown once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A nonzero page transfer starts a search
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (page != '0)) |=> (busy && !done))
    else $error("nonzero page did not start a search");

  // Page zero answers at once with an empty result
  a_zero_page: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (page == '0)) |=>
      (done && !hit && (frame == '0) && (evicted_page == '0)))
    else $error("page zero result wrong");

  // A hit evicts nothing and leaves the fault count alone
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> ((evicted_page == '0) && $stable(fault_count)))
    else $error("hit result inconsistent");

  // Fault count only moves at the end of a search
  a_fault_hold: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(fault_count))
    else $error("fault count changed while idle");

endmodule

bind lru_page_replacement_unit lru_checker u_lru_checker (.*);
